[hdl/memory_value_scan_filter_unit_defines.svh]
// assertion macros shared by the filter unit
`ifndef MEMORY_VALUE_SCAN_FILTER_UNIT_DEFINES_SVH
`define MEMORY_VALUE_SCAN_FILTER_UNIT_DEFINES_SVH

// checked while out of reset
`define MVSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MVSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mvsf_pkg.sv]
// ----------------------------------------------------------------------------
// mvsf_pkg
// types, codes and helpers of the memory value scan filter
// ----------------------------------------------------------------------------
package mvsf_pkg;

  localparam int MAX_CAND_DEF = 131072;
  localparam int LANES        = 8;
  localparam int CNT_W        = 18;

  typedef enum logic [2:0] {
    FN_CLEAR  = 3'd0,
    FN_NEW    = 3'd1,
    FN_SCAN   = 3'd2,
    FN_REFINE = 3'd3,
    FN_VALUE  = 3'd4,
    FN_READ   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    OP_EQ   = 3'd0,
    OP_NE   = 3'd1,
    OP_GT   = 3'd2,
    OP_LT   = 3'd3,
    OP_INC  = 3'd4,
    OP_DEC  = 3'd5,
    OP_SAME = 3'd6,
    OP_DIFF = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0,
    REG_OP    = 2'd1,
    REG_MATCH = 2'd2
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CMP,
    S_ORD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] word_address;
    logic [63:0] word_data;
    logic [3:0]  valid_bytes;
    logic        read_failed;
    logic [16:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] cand_count;
    logic             capped;
    logic             incomplete;
    logic             error_code;
    logic [63:0]      entry_address;
    logic [63:0]      entry_value;
    logic             entry_valid;
    logic             pass_done;
  } out_t;

  function automatic logic [63:0] lane_mask(input logic [1:0] code);
    logic [63:0] m;
    case (code)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic op_holds(input logic [2:0] op, input logic [63:0] cur,
                                    input logic [63:0] prev, input logic [63:0] match);
    logic r;
    unique case (op)
      OP_EQ:   r = (cur == match);
      OP_NE:   r = (cur != match);
      OP_GT:   r = (cur > match);
      OP_LT:   r = (cur < match);
      OP_INC:  r = (cur > prev);
      OP_DEC:  r = (cur < prev);
      OP_SAME: r = (cur == prev);
      default: r = (cur != prev);
    endcase
    return r;
  endfunction

endpackage

[hdl/memory_value_scan_filter_unit.sv]
// ----------------------------------------------------------------------------
// memory_value_scan_filter_unit
// candidate set engine: word scan over 8 byte lanes, refine passes, readout
// ----------------------------------------------------------------------------
// sequence: accept, then S_EXEC, S_ORD and S_OUT; a scan word also passes through
//   S_SCAN, which stores its matches one by one, and a refine value word through S_CMP
// throughput: one word at a time; the next word is taken once the result is registered
//   and the unit is back in S_IDLE; scan words are bound by the
//   single write port of the candidate rams; a stalled result holds the unit
// reset: control state cleared; candidate rams are not cleared
// ----------------------------------------------------------------------------
`include "memory_value_scan_filter_unit_defines.svh"

module memory_value_scan_filter_unit
  import mvsf_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CAND_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int IW = (CW > 17) ? CW : 17;
  localparam logic [CW-1:0] LAST = CW'(MAX_CANDIDATES - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] rpos_r, rpos_nxt;
  logic [CW-1:0] kpos_r, kpos_nxt;
  logic          capped_r, capped_nxt;
  logic          incompl_r, incompl_nxt;
  logic          search_r, search_nxt;
  logic          refine_r, refine_nxt;
  logic          open_r, open_nxt;
  logic [1:0]    lcode_r, lcode_nxt;
  logic [1:0]    wcode_r, wcode_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          err_r, err_nxt;
  logic          done_r, done_nxt;
  logic          ent_r, ent_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [63:0]      match_r, match_nxt;
  in_t              item_r, item_nxt;
  logic [LANES-1:0] mask_r, mask_nxt;
  out_t             out_r, out_nxt;

  logic [LANES-1:0] hits;
  logic [2:0]       first;
  logic             we;
  logic [AW-1:0]    wr_idx;
  logic [63:0]      wr_addr, wr_val;
  logic             rd_en;
  logic [AW-1:0]    rd_idx;
  logic [63:0]      addr_q, val_q;
  logic [63:0]      cur;
  logic [CW-1:0]    rpos_inc;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mvsf_lane #(.OFFSET(g)) u_lane (
      .word   (item_r.word_data),
      .code   (lcode_r),
      .vbytes (item_r.valid_bytes),
      .match  (match_r),
      .hit    (hits[g])
    );
  end

  mvsf_ram #(.WIDTH(64), .DEPTH(MAX_CANDIDATES)) u_addr_ram (
    .clk(clk), .we(we), .waddr(wr_idx), .wdata(wr_addr),
    .re(rd_en), .raddr(rd_idx), .rdata(addr_q)
  );

  mvsf_ram #(.WIDTH(64), .DEPTH(MAX_CANDIDATES)) u_val_ram (
    .clk(clk), .we(we), .waddr(wr_idx), .wdata(wr_val),
    .re(rd_en), .raddr(rd_idx), .rdata(val_q)
  );

  // lowest pending lane of the merged hit mask
  always_comb begin
    first = 3'd0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        first = 3'(i);
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign cur       = item_r.word_data & lane_mask(lcode_r);
  assign rpos_inc  = rpos_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    rpos_nxt      = rpos_r;
    kpos_nxt      = kpos_r;
    capped_nxt    = capped_r;
    incompl_nxt   = incompl_r;
    search_nxt    = search_r;
    refine_nxt    = refine_r;
    open_nxt      = open_r;
    lcode_nxt     = lcode_r;
    wcode_nxt     = wcode_r;
    op_nxt        = op_r;
    match_nxt     = match_r;
    err_nxt       = err_r;
    done_nxt      = done_r;
    ent_nxt       = ent_r;
    item_nxt      = item_r;
    mask_nxt      = mask_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    wr_idx        = held_r[AW-1:0];
    wr_addr       = item_r.word_address + 64'(first);
    wr_val        = match_r;
    rd_en         = 1'b0;
    rd_idx        = rpos_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH: wcode_nxt = cfg_data[1:0];
        REG_OP:    op_nxt    = cfg_data[2:0];
        REG_MATCH: match_nxt = cfg_data;
        default:   ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_word;
          err_nxt   = 1'b0;
          done_nxt  = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_ORD;
        case (item_r.func)
          FN_CLEAR: begin
            held_nxt    = '0;
            capped_nxt  = 1'b0;
            incompl_nxt = 1'b0;
            search_nxt  = 1'b0;
            refine_nxt  = 1'b0;
            open_nxt    = 1'b0;
          end
          FN_NEW: begin
            held_nxt    = '0;
            capped_nxt  = 1'b0;
            incompl_nxt = 1'b0;
            search_nxt  = 1'b1;
            refine_nxt  = 1'b0;
            open_nxt    = 1'b1;
            lcode_nxt   = wcode_r;
          end
          FN_SCAN: begin
            if (search_r && open_r && !capped_r) begin
              if (item_r.read_failed) begin
                incompl_nxt = 1'b1;
              end else begin
                mask_nxt  = hits;
                state_nxt = S_SCAN;
              end
            end
          end
          FN_REFINE: begin
            if (!search_r) begin
              err_nxt = 1'b1;
            end else begin
              open_nxt   = 1'b0;
              refine_nxt = 1'b1;
              rpos_nxt   = '0;
              kpos_nxt   = '0;
              if (held_r == '0) begin
                capped_nxt = 1'b0;
                refine_nxt = 1'b0;
                done_nxt   = 1'b1;
              end
            end
          end
          FN_VALUE: begin
            if (!search_r) begin
              err_nxt = 1'b1;
            end else if (refine_r) begin
              rd_en     = 1'b1;
              state_nxt = S_CMP;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (mask_r == '0) begin
          state_nxt = S_ORD;
        end else begin
          we                = 1'b1;
          held_nxt          = held_r + CW'(1);
          mask_nxt[first]   = 1'b0;
          if (held_r == LAST) begin
            capped_nxt = 1'b1;
            state_nxt  = S_ORD;
          end
        end
      end
      S_CMP: begin
        // rams now hold the candidate at the read position
        if (rpos_r < held_r) begin
          if (item_r.read_failed) begin
            incompl_nxt = 1'b1;
          end else if (op_holds(op_r, cur, val_q, match_r)) begin
            we       = 1'b1;
            wr_idx   = kpos_r[AW-1:0];
            wr_addr  = addr_q;
            wr_val   = cur;
            kpos_nxt = kpos_r + CW'(1);
          end
        end
        rpos_nxt = rpos_inc;
        if (rpos_inc >= held_r) begin
          held_nxt   = kpos_nxt;
          capped_nxt = 1'b0;
          refine_nxt = 1'b0;
          done_nxt   = 1'b1;
        end
        state_nxt = S_ORD;
      end
      S_ORD: begin
        rd_en = 1'b1;
        if (item_r.func == FN_READ) begin
          rd_idx  = AW'(item_r.entry_index);
          ent_nxt = search_r && (IW'(item_r.entry_index) < IW'(held_r));
        end else begin
          ent_nxt = refine_r && (rpos_r < held_r);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.cand_count    = CNT_W'(held_r);
          out_nxt.capped        = capped_r;
          out_nxt.incomplete    = incompl_r;
          out_nxt.error_code    = err_r;
          out_nxt.entry_address = ent_r ? addr_q : 64'd0;
          out_nxt.entry_value   = ent_r ? val_q : 64'd0;
          out_nxt.entry_valid   = ent_r;
          out_nxt.pass_done     = done_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      rpos_r      <= '0;
      kpos_r      <= '0;
      capped_r    <= 1'b0;
      incompl_r   <= 1'b0;
      search_r    <= 1'b0;
      refine_r    <= 1'b0;
      open_r      <= 1'b0;
      lcode_r     <= 2'd2;
      wcode_r     <= 2'd2;
      op_r        <= OP_EQ;
      match_r     <= '0;
      err_r       <= 1'b0;
      done_r      <= 1'b0;
      ent_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      rpos_r      <= rpos_nxt;
      kpos_r      <= kpos_nxt;
      capped_r    <= capped_nxt;
      incompl_r   <= incompl_nxt;
      search_r    <= search_nxt;
      refine_r    <= refine_nxt;
      open_r      <= open_nxt;
      lcode_r     <= lcode_nxt;
      wcode_r     <= wcode_nxt;
      op_r        <= op_nxt;
      match_r     <= match_nxt;
      err_r       <= err_nxt;
      done_r      <= done_nxt;
      ent_r       <= ent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    mask_r <= mask_nxt;
    out_r  <= out_nxt;
  end

  `MVSF_ASSERT(a_held_max, held_r <= CW'(MAX_CANDIDATES), "candidate count above store depth")
  `MVSF_ASSERT(a_capped_full, capped_r |-> held_r == CW'(MAX_CANDIDATES), "capped while not full")
  `MVSF_ASSERT(a_refine_search, refine_r |-> search_r, "refine pass without a search")
  `MVSF_ASSERT(a_keep_read, refine_r |-> kpos_r <= rpos_r, "keep position passed read position")
  `MVSF_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "not idle after reset")

endmodule

[hdl/mvsf_ram.sv]
// ----------------------------------------------------------------------------
// mvsf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mvsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mvsf_lane.sv]
// ----------------------------------------------------------------------------
// mvsf_lane
// compares the element starting at one byte offset of a word with the match value
// ----------------------------------------------------------------------------
module mvsf_lane
  import mvsf_pkg::*;
#(
  parameter int OFFSET = 0
) (
  input  logic [63:0] word,
  input  logic [1:0]  code,
  input  logic [3:0]  vbytes,
  input  logic [63:0] match,
  output logic        hit
);

  logic [3:0]  size;
  logic [3:0]  vb8;
  logic [63:0] elem;
  logic        aligned;
  logic        fits;

  always_comb begin
    size    = 4'd1 << code;
    vb8     = (vbytes > 4'd8) ? 4'd8 : vbytes;
    elem    = (word >> (8 * OFFSET)) & lane_mask(code);
    aligned = ((4'(OFFSET) & (size - 4'd1)) == 4'd0);
    fits    = ((5'(OFFSET) + 5'(size)) <= 5'(vb8));
    hit     = aligned && fits && (elem == match);
  end

endmodule

[bench/tb_memory_value_scan_filter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_memory_value_scan_filter_unit
// scan, refine and readout checks of the candidate set engine: queued words
// are driven with random gaps and every result word is checked against a local
// candidate set model
// ----------------------------------------------------------------------------
module tb_memory_value_scan_filter_unit;
  import mvsf_pkg::*;

  localparam int MAX_CAND = MAX_CAND_DEF;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  memory_value_scan_filter_unit i_dut (.*);

  always #10 clk = ~clk;

  // candidate set model
  logic [63:0] addr_mem [int];
  logic [63:0] value_mem [int];
  int unsigned held_n;
  logic capped_f, incompl_f, search_on, refine_on, scan_open_f;
  int unsigned rd_pos, keep_pos;
  logic [1:0]  lane_code_l, reg_width;
  logic [2:0]  reg_op;
  logic [63:0] reg_match;

  in_t  pend_q[$];
  out_t status_q[$];
  int   n_errors = 0;
  int   cycles = 0;
  bit   pace_on = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;

  function automatic logic [63:0] mask_of(logic [1:0] code);
    return (code == 2'd3) ? '1 : ((64'd1 << (8 << code)) - 64'd1);
  endfunction

  function automatic logic cmp_holds(logic [63:0] cur, logic [63:0] prev);
    case (op_t'(reg_op))
      OP_EQ:   return cur == reg_match;
      OP_NE:   return cur != reg_match;
      OP_GT:   return cur > reg_match;
      OP_LT:   return cur < reg_match;
      OP_INC:  return cur > prev;
      OP_DEC:  return cur < prev;
      OP_SAME: return cur == prev;
      default: return cur != prev;
    endcase
  endfunction

  function automatic void model_reset();
    held_n = 0; capped_f = 0; incompl_f = 0; search_on = 0; refine_on = 0;
    rd_pos = 0; keep_pos = 0; scan_open_f = 0; lane_code_l = 2'd2;
    reg_width = 2'd2; reg_op = OP_EQ; reg_match = '0;
  endfunction

  function automatic void end_pass();
    held_n = keep_pos;
    capped_f = 0;
    refine_on = 0;
  endfunction

  function automatic out_t predict_status(in_t it);
    out_t r;
    int unsigned w, vb, off;
    logic [63:0] lane, cur;
    r = '0;
    case (it.func)
      FN_CLEAR: begin
        held_n = 0; capped_f = 0; incompl_f = 0;
        search_on = 0; refine_on = 0; scan_open_f = 0;
      end
      FN_NEW: begin
        held_n = 0; capped_f = 0; incompl_f = 0;
        search_on = 1; refine_on = 0; scan_open_f = 1;
        lane_code_l = reg_width;
      end
      FN_SCAN: begin
        if (search_on && scan_open_f && !capped_f) begin
          if (it.read_failed) begin
            incompl_f = 1;
          end else begin
            w = 1 << lane_code_l;
            vb = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
            for (off = 0; off + w <= vb; off += w) begin
              lane = (it.word_data >> (8 * off)) & mask_of(lane_code_l);
              if (lane == reg_match) begin
                addr_mem[held_n] = it.word_address + off;
                value_mem[held_n] = reg_match;
                held_n++;
                if (held_n >= MAX_CAND) begin
                  capped_f = 1;
                  break;
                end
              end
            end
          end
        end
      end
      FN_REFINE: begin
        if (!search_on) begin
          r.error_code = 1;
        end else begin
          scan_open_f = 0; refine_on = 1; rd_pos = 0; keep_pos = 0;
          if (held_n == 0) begin
            end_pass();
            r.pass_done = 1;
          end
        end
      end
      FN_VALUE: begin
        if (!search_on) begin
          r.error_code = 1;
        end else if (refine_on) begin
          if (rd_pos < held_n) begin
            if (it.read_failed) begin
              incompl_f = 1;
            end else begin
              cur = it.word_data & mask_of(lane_code_l);
              if (cmp_holds(cur, value_mem[rd_pos])) begin
                addr_mem[keep_pos] = addr_mem[rd_pos];
                value_mem[keep_pos] = cur;
                keep_pos++;
              end
            end
          end
          rd_pos++;
          if (rd_pos >= held_n) begin
            end_pass();
            r.pass_done = 1;
          end
        end
      end
      FN_READ: begin
        if (search_on && it.entry_index < held_n) begin
          r.entry_address = addr_mem[it.entry_index];
          r.entry_value = value_mem[it.entry_index];
          r.entry_valid = 1;
        end
      end
      default: ;
    endcase
    if (it.func != FN_READ && refine_on && rd_pos < held_n) begin
      r.entry_address = addr_mem[rd_pos];
      r.entry_value = value_mem[rd_pos];
      r.entry_valid = 1;
    end
    r.cand_count = CNT_W'(held_n);
    r.capped = capped_f;
    r.incomplete = incompl_f;
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", field, got, want, $realtime);
    n_errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_word <= pend_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= pace_on ? $urandom_range(0, 6) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction on accepted input words
  always @(posedge clk) begin
    if (!rst_n) model_reset();
    else if (in_valid && !in_stall) status_q.push_back(predict_status(in_word));
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report("unexpected word", out_word.cand_count, 0);
        end else begin
          want = status_q.pop_front();
          if (out_word.cand_count !== want.cand_count)
            report("cand_count", out_word.cand_count, want.cand_count);
          if (out_word.capped !== want.capped) report("capped", out_word.capped, want.capped);
          if (out_word.incomplete !== want.incomplete)
            report("incomplete", out_word.incomplete, want.incomplete);
          if (out_word.error_code !== want.error_code)
            report("error_code", out_word.error_code, want.error_code);
          if (out_word.entry_address !== want.entry_address)
            report("entry_address", out_word.entry_address, want.entry_address);
          if (out_word.entry_value !== want.entry_value)
            report("entry_value", out_word.entry_value, want.entry_value);
          if (out_word.entry_valid !== want.entry_valid)
            report("entry_valid", out_word.entry_valid, want.entry_valid);
          if (out_word.pass_done !== want.pass_done)
            report("pass_done", out_word.pass_done, want.pass_done);
        end
        stall_left <= pace_on ? $urandom_range(0, 6) : 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_t rand_word(logic [2:0] f);
    in_t it;
    it.func = f;
    it.word_address = {$urandom, $urandom};
    it.word_data = {$urandom, $urandom};
    it.valid_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 4'd8;
    it.read_failed = ($urandom_range(0, 11) == 0);
    it.entry_index = $urandom_range(0, 131071);
    return it;
  endfunction

  function automatic in_t fixed_word(logic [2:0] f, logic [63:0] d, logic [3:0] vb);
    in_t it;
    it = rand_word(f);
    it.word_data = d;
    it.valid_bytes = vb;
    it.read_failed = 1'b0;
    return it;
  endfunction

  // scan data with about a third of the lanes hitting the match value
  function automatic logic [63:0] hit_data(logic [1:0] code);
    logic [63:0] d, m, lane;
    int w;
    m = mask_of(code);
    w = 1 << code;
    d = {$urandom, $urandom};
    for (int off = 0; off < 8; off += w) begin
      lane = ($urandom_range(0, 2) == 0) ? reg_match : {$urandom, $urandom};
      d = (d & ~(m << (8 * off))) | ((lane & m) << (8 * off));
    end
    return d;
  endfunction

  task automatic write_reg(reg_t idx, logic [63:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH: reg_width = d[1:0];
      REG_OP:    reg_op = d[2:0];
      default:   reg_match = d;
    endcase
  endtask

  // checked away from the rising edge so the driver's updates have settled
  task automatic drain();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || status_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_match(logic [1:0] code);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return mask_of(code);
      2: return {$urandom, $urandom};
      3: return $urandom_range(0, 3);
      default: return {$urandom, $urandom} & mask_of(code);
    endcase
  endfunction

  // one refine value per held candidate, in order, with an occasional break
  task automatic queue_refine_pass();
    logic [63:0] prev, v, m;
    in_t it;
    m = mask_of(lane_code_l);
    pend_q.push_back(rand_word(FN_REFINE));
    for (int i = 0; i < held_n; i++) begin
      prev = value_mem[i];
      case ($urandom_range(0, 4))
        0: v = prev;
        1: v = prev + 1;
        2: v = prev - 1;
        3: v = reg_match;
        default: v = {$urandom, $urandom};
      endcase
      it = rand_word(FN_VALUE);
      it.word_data = (v & m) | ({$urandom, $urandom} & ~m);
      pend_q.push_back(it);
      if ($urandom_range(0, 7) == 0) pend_q.push_back(rand_word(FN_READ));
      if ($urandom_range(0, 60) == 0)
        pend_q.push_back(rand_word($urandom_range(0, 1) ? FN_REFINE : FN_CLEAR));
    end
  endtask

  initial begin
    int sent;
    int nscan;
    in_t it;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: nothing active yet, then the lane corner cases
    pend_q.push_back(rand_word(FN_REFINE));
    pend_q.push_back(rand_word(FN_VALUE));
    pend_q.push_back(rand_word(FN_READ));
    pend_q.push_back(fixed_word(FN_SCAN, '0, 4'd8));
    pend_q.push_back(rand_word(FN_SPARE6));
    pend_q.push_back(rand_word(FN_SPARE7));
    pend_q.push_back(rand_word(FN_CLEAR));
    drain();
    write_reg(REG_WIDTH, 64'd3);
    write_reg(REG_MATCH, '1);
    write_reg(REG_OP, OP_SAME);
    pend_q.push_back(rand_word(FN_NEW));
    pend_q.push_back(fixed_word(FN_SCAN, '1, 4'd8));
    pend_q.push_back(fixed_word(FN_SCAN, '1, 4'd15));
    pend_q.push_back(fixed_word(FN_SCAN, '1, 4'd0));
    pend_q.push_back(fixed_word(FN_SCAN, '1, 4'd7));
    it = fixed_word(FN_SCAN, '1, 4'd8);
    it.read_failed = 1'b1;
    pend_q.push_back(it);
    it = fixed_word(FN_READ, '0, 4'd8);
    it.entry_index = 17'd1;
    pend_q.push_back(it);
    drain();
    queue_refine_pass();
    drain();
    // match wider than the lane never hits, so the pass ends at once
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_MATCH, 64'h1ff);
    pend_q.push_back(rand_word(FN_NEW));
    pend_q.push_back(fixed_word(FN_SCAN, '1, 4'd8));
    pend_q.push_back(rand_word(FN_REFINE));
    pend_q.push_back(rand_word(FN_VALUE));
    pend_q.push_back(fixed_word(FN_SCAN, '1, 4'd8));
    drain();

    // random phases: new search, scans, refine passes, readout
    sent = 0;
    while (sent < 550) begin
      pace_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_WIDTH, $urandom_range(0, 3));
      write_reg(REG_OP, $urandom_range(0, 7));
      write_reg(REG_MATCH, pick_match(reg_width));
      pend_q.push_back(rand_word(($urandom_range(0, 9) == 0) ? FN_CLEAR : FN_NEW));
      nscan = $urandom_range(2, 10);
      for (int i = 0; i < nscan; i++) begin
        it = rand_word(FN_SCAN);
        it.word_data = hit_data(reg_width);
        pend_q.push_back(it);
        if ($urandom_range(0, 9) == 0) pend_q.push_back(rand_word($urandom_range(4, 7)));
      end
      sent += nscan + 1;
      drain();
      for (int p = $urandom_range(1, 2); p > 0; p--) begin
        if ($urandom_range(0, 1)) write_reg(REG_OP, $urandom_range(0, 7));
        sent += held_n + 1;
        queue_refine_pass();
        drain();
      end
      for (int i = 0; i < 3; i++) begin
        it = rand_word(FN_READ);
        if (held_n > 0 && i < 2) it.entry_index = $urandom_range(0, held_n - 1);
        pend_q.push_back(it);
      end
      sent += 3;
      drain();
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0 && status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
